FILE: rtl/core/rcyl_pkg.sv
// ----------------------------------------------------------------------------
// rcyl_pkg
// shared widths, pipeline stage map and types for the ray/cylinder core
// ----------------------------------------------------------------------------
`default_nettype none

package rcyl_pkg;

  localparam int unsigned CRD_W    = 32;   // Q16.16 coordinate
  localparam int unsigned RAD_W    = 31;
  localparam int unsigned RSQ_W    = 62;
  localparam int unsigned A_W      = 64;
  localparam int unsigned B_W      = 65;
  localparam int unsigned D_W      = 126;  // discriminant, below 2^125
  localparam int unsigned ROOT_W   = 63;
  localparam int unsigned REM_W    = 64;
  localparam int unsigned N_W      = 66;
  localparam int unsigned P_W      = 96;
  localparam int unsigned Q_W      = 34;
  localparam int unsigned ADDR_W   = 3;

  localparam int unsigned SQ_STEPS  = ROOT_W;
  localparam int unsigned DIV_STEPS = Q_W;

  // pipeline stage map
  localparam int unsigned ST_MUL   = 0;
  localparam int unsigned ST_ABX   = 1;
  localparam int unsigned ST_ABS   = 2;
  localparam int unsigned ST_PP    = 3;
  localparam int unsigned ST_CROSS = 4;
  localparam int unsigned ST_SUMS  = 5;
  localparam int unsigned ST_DISC  = 6;
  localparam int unsigned ST_SQ0   = 7;
  localparam int unsigned ST_N     = ST_SQ0 + SQ_STEPS;
  localparam int unsigned ST_MAG   = ST_N + 1;
  localparam int unsigned ST_PPN   = ST_MAG + 1;
  localparam int unsigned ST_P     = ST_PPN + 1;
  localparam int unsigned ST_OVF   = ST_P + 1;
  localparam int unsigned ST_DV0   = ST_OVF + 1;
  localparam int unsigned ST_RND   = ST_DV0 + DIV_STEPS;
  localparam int unsigned NSTG     = ST_RND + 1;

  localparam logic [0:0] REG_RADIUS = 1'b0;
  localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;

  localparam logic [Q_W:0]     Q_LIM   = 35'h2_0000_0000;
  localparam logic [CRD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [CRD_W-1:0] SAT_MIN = 32'h8000_0000;

  // data that rides along the pipeline with each ray
  typedef struct packed {
    logic [2:0][CRD_W-1:0] dir;
    logic [2:0][CRD_W-1:0] orig;
    logic [A_W-1:0]        a;
    logic [B_W-1:0]        b;
    logic                  nohit;
    logic [2:0]            neg;
    logic [2:0]            ovf;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/core/ray_cylinder_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_cylinder_intersect_core
// far-side intersection of a Q16.16 ray with a Y-axis cylinder, fully pipelined
// throughput: one ray per cycle unless the output stalls; 63 square root steps
// and 34 divide steps each take one stage, and the whole pipe advances on one
// enable
// reset: synchronous active-low rst_n clears valid bits and sets radius to 1.0
// ----------------------------------------------------------------------------
`default_nettype none

module ray_cylinder_intersect_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  in_dir_x,
  input  wire logic signed [31:0]  in_dir_y,
  input  wire logic signed [31:0]  in_dir_z,
  input  wire logic signed [31:0]  in_orig_x,
  input  wire logic signed [31:0]  in_orig_y,
  input  wire logic signed [31:0]  in_orig_z,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_hit_x,
  output logic signed [31:0]       out_hit_y,
  output logic signed [31:0]       out_hit_z,
  output logic                     out_no_hit,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned NSTG = rcyl_pkg::NSTG;

  // ---------------- configuration ----------------
  logic [rcyl_pkg::RAD_W-1:0] radius_r;
  logic [rcyl_pkg::RSQ_W-1:0] rsq_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[rcyl_pkg::ADDR_W-1] == rcyl_pkg::REG_RADIUS);
  assign prdata = (paddr[rcyl_pkg::ADDR_W-1] == rcyl_pkg::REG_RADIUS) ?
                  {1'b0, radius_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= rcyl_pkg::RADIUS_RST;
    end else if (cfg_wr) begin
      radius_r <= pwdata[rcyl_pkg::RAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rsq_r <= radius_r * radius_r;
  end

  // ---------------- flow control ----------------
  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;
  logic            out_load;
  logic            pipe_en;

  assign out_load = !out_valid_r || out_ready;
  // a bubble in the last stage lets the pipe move while a result waits
  assign pipe_en  = out_load || !vld_r[NSTG-1];
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // ---------------- side data ----------------
  rcyl_pkg::side_t side_r [NSTG];
  rcyl_pkg::side_t side_in;
  rcyl_pkg::side_t side_abx_nxt;
  rcyl_pkg::side_t side_abs_nxt;
  rcyl_pkg::side_t side_disc_nxt;
  rcyl_pkg::side_t side_mag_nxt;
  rcyl_pkg::side_t side_ovf_nxt;

  // ---------------- stage registers ----------------
  logic signed [63:0] m_xx_r, m_zz_r, m_xo_r, m_zo_r, m_xoz_r, m_zox_r;
  logic [64:0]        x_r;
  logic [64:0]        x_neg;
  logic [63:0]        xm_r;
  logic [63:0]        xm_nxt;
  logic [63:0]        pa00_r, pa01_r, pa10_r, pa11_r;
  logic [63:0]        px00_r, px01_r, px11_r;
  logic [64:0]        ma_r;
  logic [63:0]        mx_r;
  logic [127:0]       cata_r, catx_r;
  logic [127:0]       ar_r, x2_r;
  logic [128:0]       disc;
  logic [rcyl_pkg::D_W-1:0] d_r;

  logic [rcyl_pkg::D_W-1:0]    sq_d_r    [rcyl_pkg::SQ_STEPS];
  logic [rcyl_pkg::REM_W-1:0]  sq_rem_r  [rcyl_pkg::SQ_STEPS];
  logic [rcyl_pkg::ROOT_W-1:0] sq_root_r [rcyl_pkg::SQ_STEPS];

  logic [rcyl_pkg::N_W-1:0] n_r;
  logic [rcyl_pkg::N_W-1:0] n_abs;
  logic [63:0]              nmag_r;
  logic [2:0][31:0]         dmag_r;
  logic [2:0][63:0]         ppl_r, pph_r;
  logic [2:0][rcyl_pkg::P_W-1:0] p_r;

  logic [2:0][rcyl_pkg::REM_W-1:0] dv0_rem_r;
  logic [2:0][rcyl_pkg::Q_W-1:0]   dv0_pb_r;
  logic [2:0][rcyl_pkg::REM_W-1:0] dv_rem_r [rcyl_pkg::DIV_STEPS];
  logic [2:0][rcyl_pkg::Q_W-1:0]   dv_q_r   [rcyl_pkg::DIV_STEPS];
  logic [2:0][rcyl_pkg::Q_W-1:0]   dv_pb_r  [rcyl_pkg::DIV_STEPS];

  logic [2:0][rcyl_pkg::Q_W-1:0]   qc_r;
  logic [2:0][rcyl_pkg::Q_W-1:0]   qc_nxt;
  logic [2:0][31:0]                hit_nxt;
  logic [2:0][31:0]                hit_r;
  logic                            no_hit_r;

  always_comb begin
    side_in         = '0;
    side_in.dir[0]  = in_dir_x;
    side_in.dir[1]  = in_dir_y;
    side_in.dir[2]  = in_dir_z;
    side_in.orig[0] = in_orig_x;
    side_in.orig[1] = in_orig_y;
    side_in.orig[2] = in_orig_z;
  end

  // A, B and the cross term X
  always_comb begin
    side_abx_nxt   = side_r[rcyl_pkg::ST_ABX-1];
    side_abx_nxt.a = $unsigned(m_xx_r) + $unsigned(m_zz_r);
    side_abx_nxt.b = {m_xo_r[63], m_xo_r} + {m_zo_r[63], m_zo_r};
  end

  always_comb begin
    side_abs_nxt       = side_r[rcyl_pkg::ST_ABS-1];
    side_abs_nxt.nohit = (side_r[rcyl_pkg::ST_ABS-1].a == '0);
    x_neg              = ~x_r + 65'd1;
    xm_nxt             = x_r[64] ? x_neg[63:0] : x_r[63:0];
  end

  always_comb begin
    disc                = {1'b0, ar_r} - {1'b0, x2_r};
    side_disc_nxt       = side_r[rcyl_pkg::ST_DISC-1];
    side_disc_nxt.nohit = side_r[rcyl_pkg::ST_DISC-1].nohit | disc[128];
  end

  always_comb begin
    n_abs        = n_r[rcyl_pkg::N_W-1] ? (~n_r + 66'd1) : n_r;
    side_mag_nxt = side_r[rcyl_pkg::ST_MAG-1];
    for (int k = 0; k < 3; k++) begin
      side_mag_nxt.neg[k] = side_r[rcyl_pkg::ST_MAG-1].dir[k][31] ^ n_r[rcyl_pkg::N_W-1];
    end
  end

  always_comb begin
    side_ovf_nxt = side_r[rcyl_pkg::ST_OVF-1];
    for (int k = 0; k < 3; k++) begin
      side_ovf_nxt.ovf[k] = ({2'b00, p_r[k]} >= {side_r[rcyl_pkg::ST_OVF-1].a, 34'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side_r[0] <= side_in;
      for (int k = 1; k < NSTG; k++) begin
        case (k)
          rcyl_pkg::ST_ABX:  side_r[k] <= side_abx_nxt;
          rcyl_pkg::ST_ABS:  side_r[k] <= side_abs_nxt;
          rcyl_pkg::ST_DISC: side_r[k] <= side_disc_nxt;
          rcyl_pkg::ST_MAG:  side_r[k] <= side_mag_nxt;
          rcyl_pkg::ST_OVF:  side_r[k] <= side_ovf_nxt;
          default:           side_r[k] <= side_r[k-1];
        endcase
      end
    end
  end

  // front end: products, quadratic terms, discriminant
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_xx_r  <= in_dir_x * in_dir_x;
      m_zz_r  <= in_dir_z * in_dir_z;
      m_xo_r  <= in_dir_x * in_orig_x;
      m_zo_r  <= in_dir_z * in_orig_z;
      m_xoz_r <= in_dir_x * in_orig_z;
      m_zox_r <= in_dir_z * in_orig_x;

      x_r  <= {m_xoz_r[63], m_xoz_r} - {m_zox_r[63], m_zox_r};
      xm_r <= xm_nxt;

      // A * r^2 and X^2 as 32x32 partial products
      pa00_r <= side_r[rcyl_pkg::ST_PP-1].a[31:0]  * rsq_r[31:0];
      pa01_r <= side_r[rcyl_pkg::ST_PP-1].a[31:0]  * {2'b00, rsq_r[61:32]};
      pa10_r <= side_r[rcyl_pkg::ST_PP-1].a[63:32] * rsq_r[31:0];
      pa11_r <= side_r[rcyl_pkg::ST_PP-1].a[63:32] * {2'b00, rsq_r[61:32]};
      px00_r <= xm_r[31:0]  * xm_r[31:0];
      px01_r <= xm_r[31:0]  * xm_r[63:32];
      px11_r <= xm_r[63:32] * xm_r[63:32];

      ma_r   <= {1'b0, pa01_r} + {1'b0, pa10_r};
      cata_r <= {pa11_r, pa00_r};
      mx_r   <= px01_r;
      catx_r <= {px11_r, px00_r};

      ar_r <= cata_r + {31'b0, ma_r, 32'b0};
      x2_r <= catx_r + {31'b0, mx_r, 33'b0};

      d_r <= disc[rcyl_pkg::D_W-1:0];
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < rcyl_pkg::SQ_STEPS; j++) begin : g_sq
    logic [rcyl_pkg::D_W-1:0]    d_in;
    logic [rcyl_pkg::REM_W-1:0]  rem_in;
    logic [rcyl_pkg::ROOT_W-1:0] root_in;
    logic [65:0]                 cur;
    logic [65:0]                 trial;
    logic [65:0]                 sub;

    if (j == 0) begin : g_first
      assign d_in    = d_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign d_in    = sq_d_r[j-1];
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
    end

    assign cur   = {rem_in, d_in[rcyl_pkg::D_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign sub   = cur - trial;

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sq_d_r[j] <= {d_in[rcyl_pkg::D_W-3:0], 2'b00};
        if (cur >= trial) begin
          sq_rem_r[j]  <= sub[63:0];
          sq_root_r[j] <= {root_in[rcyl_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_r[j]  <= cur[63:0];
          sq_root_r[j] <= {root_in[rcyl_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // numerator S - B, then |d| * |n| per axis
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      n_r <= {3'b000, sq_root_r[rcyl_pkg::SQ_STEPS-1]} -
             {side_r[rcyl_pkg::ST_N-1].b[64], side_r[rcyl_pkg::ST_N-1].b};
      nmag_r <= n_abs[63:0];
      for (int k = 0; k < 3; k++) begin
        dmag_r[k] <= side_r[rcyl_pkg::ST_MAG-1].dir[k][31] ?
                     (~side_r[rcyl_pkg::ST_MAG-1].dir[k] + 32'd1) :
                     side_r[rcyl_pkg::ST_MAG-1].dir[k];
        ppl_r[k]  <= dmag_r[k] * nmag_r[31:0];
        pph_r[k]  <= dmag_r[k] * nmag_r[63:32];
        p_r[k]    <= {32'b0, ppl_r[k]} + {pph_r[k], 32'b0};
        dv0_rem_r[k] <= {2'b00, p_r[k][rcyl_pkg::P_W-1:rcyl_pkg::Q_W]};
        dv0_pb_r[k]  <= p_r[k][rcyl_pkg::Q_W-1:0];
      end
    end
  end

  // restoring divide by A, one quotient bit per stage
  for (genvar i = 0; i < rcyl_pkg::DIV_STEPS; i++) begin : g_dv
    logic [2:0][rcyl_pkg::REM_W-1:0] rem_in;
    logic [2:0][rcyl_pkg::Q_W-1:0]   q_in;
    logic [2:0][rcyl_pkg::Q_W-1:0]   pb_in;
    logic [rcyl_pkg::A_W-1:0]        div_a;

    assign div_a = side_r[rcyl_pkg::ST_DV0+i-1].a;

    if (i == 0) begin : g_first
      assign rem_in = dv0_rem_r;
      assign q_in   = '0;
      assign pb_in  = dv0_pb_r;
    end else begin : g_next
      assign rem_in = dv_rem_r[i-1];
      assign q_in   = dv_q_r[i-1];
      assign pb_in  = dv_pb_r[i-1];
    end

    for (genvar k = 0; k < 3; k++) begin : g_ax
      logic [64:0] cur;
      logic [64:0] sub;
      logic        ge;

      assign cur = {rem_in[k], pb_in[k][rcyl_pkg::Q_W-1]};
      assign sub = cur - {1'b0, div_a};
      assign ge  = (cur >= {1'b0, div_a});

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          dv_rem_r[i][k] <= ge ? sub[63:0] : cur[63:0];
          dv_q_r[i][k]   <= {q_in[k][rcyl_pkg::Q_W-2:0], ge};
          dv_pb_r[i][k]  <= {pb_in[k][rcyl_pkg::Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // round half away from zero and clamp the step length
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [64:0]             rem2;
      logic [rcyl_pkg::Q_W:0]  qr;
      rem2 = {dv_rem_r[rcyl_pkg::DIV_STEPS-1][k], 1'b0};
      qr   = {1'b0, dv_q_r[rcyl_pkg::DIV_STEPS-1][k]} +
             {{rcyl_pkg::Q_W{1'b0}}, (rem2 >= {1'b0, side_r[rcyl_pkg::ST_RND-1].a})};
      if (side_r[rcyl_pkg::ST_RND-1].ovf[k] || (qr > rcyl_pkg::Q_LIM)) begin
        qc_nxt[k] = rcyl_pkg::Q_LIM[rcyl_pkg::Q_W-1:0];
      end else begin
        qc_nxt[k] = qr[rcyl_pkg::Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      qc_r <= qc_nxt;
    end
  end

  // origin plus signed step, saturated
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [35:0] ov;
      logic [35:0] sv;
      ov = {{4{side_r[NSTG-1].orig[k][31]}}, side_r[NSTG-1].orig[k]};
      sv = side_r[NSTG-1].neg[k] ? (ov - {2'b00, qc_r[k]}) : (ov + {2'b00, qc_r[k]});
      if (side_r[NSTG-1].nohit) begin
        hit_nxt[k] = '0;
      end else if (sv[35] && !(&sv[34:31])) begin
        hit_nxt[k] = rcyl_pkg::SAT_MIN;
      end else if (!sv[35] && (|sv[34:31])) begin
        hit_nxt[k] = rcyl_pkg::SAT_MAX;
      end else begin
        hit_nxt[k] = sv[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit_r    <= hit_nxt;
      no_hit_r <= side_r[NSTG-1].nohit;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit_x  = hit_r[0];
  assign out_hit_y  = hit_r[1];
  assign out_hit_z  = hit_r[2];
  assign out_no_hit = no_hit_r;

  // ---------------- assertions ----------------
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_hit) |-> (out_hit_x == 0 && out_hit_y == 0 && out_hit_z == 0))
    else $error("miss beat carries nonzero coordinates");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> (vld_r == $past(vld_r)))
    else $error("pipe valid bits moved during stall");

  a_ready_why: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && vld_r[NSTG-1]))
    else $error("input blocked without a full pipe end");

endmodule

`default_nettype wire

FILE: sim/ray_cylinder_intersect_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_cylinder_intersect_checker
// watches the ray and hit channels and the register port, predicts the far
// cylinder hit point of every accepted ray and compares each hit beat with it
// ----------------------------------------------------------------------------

module ray_cylinder_intersect_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic signed [31:0] in_orig_x,
  input  logic signed [31:0] in_orig_y,
  input  logic signed [31:0] in_orig_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_hit_x,
  input  logic signed [31:0] out_hit_y,
  input  logic signed [31:0] out_hit_z,
  input  logic               out_no_hit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 hits_pending,
  output int                 errors
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               miss;
  } hit_t;

  logic [rcyl_pkg::RAD_W-1:0] radius_q;
  hit_t                       hit_q[$];

  // one coordinate: o + round(d * n / a), quotient clamped, sum saturated
  function automatic logic signed [31:0] hit_coord(input logic signed [31:0] o,
                                                   input logic signed [31:0] d,
                                                   input logic [63:0] nmag,
                                                   input logic nneg,
                                                   input logic [127:0] a);
    logic signed [127:0] sd;
    logic [127:0]        dm, p, q, r;
    logic signed [63:0]  qc, v;
    sd = d;
    dm = (sd < 0) ? -sd : sd;
    p  = dm * nmag;
    q  = p / a;
    r  = p % a;
    if (r >= a - r) q = q + 1;
    qc = (q > (128'd1 << 33)) ? (64'sd1 <<< 33) : $signed(q[63:0]);
    v  = o;
    v  = ((d < 0) ^ nneg) ? v - qc : v + qc;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic hit_t cylinder_hit(input logic [rcyl_pkg::RAD_W-1:0] rad,
                                        input logic signed [31:0] dx, dy, dz,
                                        input logic signed [31:0] ox, oy, oz);
    logic signed [127:0] sdx, sdz, sox, soz, bb, xx, nn;
    logic [127:0]        aa, xm, rr, ar, x2, disc, root, cand, nmag;
    logic                nneg;
    hit_t                h;
    sdx = dx; sdz = dz; sox = ox; soz = oz;
    aa  = sdx * sdx + sdz * sdz;
    bb  = sdx * sox + sdz * soz;
    xx  = sdx * soz - sdz * sox;
    xm  = (xx < 0) ? -xx : xx;
    rr  = rad;
    rr  = rr * rr;
    ar  = aa * rr;
    x2  = xm * xm;
    h   = '0;
    if (aa == 0 || ar < x2) begin
      h.miss = 1'b1;
      return h;
    end
    disc = ar - x2;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= disc) root = cand;
    end
    nn   = $signed(root) - bb;
    nneg = nn < 0;
    nmag = nneg ? -nn : nn;
    h.x  = hit_coord(ox, dx, nmag[63:0], nneg, aa);
    h.y  = hit_coord(oy, dy, nmag[63:0], nneg, aa);
    h.z  = hit_coord(oz, dz, nmag[63:0], nneg, aa);
    return h;
  endfunction

  assign hits_pending = hit_q.size();

  always @(posedge clk) begin
    hit_t want;
    hit_t got;
    if (!rst_n) begin
      radius_q = rcyl_pkg::RADIUS_RST;
      errors   = 0;
      hit_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0)
        radius_q = pwdata[rcyl_pkg::RAD_W-1:0];
      if (out_valid && out_ready) begin
        got = '{out_hit_x, out_hit_y, out_hit_z, out_no_hit};
        if (hit_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected hit beat: x=%h y=%h z=%h no_hit=%b",
                     got.x, got.y, got.z, got.miss);
        end else begin
          want = hit_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("hit beat differs: exp x=%h y=%h z=%h no_hit=%b,",
                       want.x, want.y, want.z, want.miss,
                       " got x=%h y=%h z=%h no_hit=%b",
                       got.x, got.y, got.z, got.miss);
          end
        end
      end
      if (in_valid && in_ready)
        hit_q.push_back(cylinder_hit(radius_q, in_dir_x, in_dir_y, in_dir_z,
                                     in_orig_x, in_orig_y, in_orig_z));
    end
  end

endmodule

FILE: sim/ray_cylinder_intersect_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_cylinder_intersect_core_test
// drives rays with random gaps under several cylinder radii, stalls the hit
// channel at random and once for a long stretch; the checker judges the beats
// ----------------------------------------------------------------------------

module ray_cylinder_intersect_core_test;

  localparam int ONE       = 65536;
  localparam int PHASE_LEN = 250;
  localparam int LIMIT     = 600000;

  typedef struct packed {
    logic signed [31:0] dx, dy, dz, ox, oy, oz;
  } ray_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [31:0] in_orig_x = '0, in_orig_y = '0, in_orig_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_hit_x, out_hit_y, out_hit_z;
  logic               out_no_hit;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int  hits_pending, errors;
  int  cycles = 0;
  int  rays_sent = 0;
  int  hold_left = 0;
  int  drain_gap = 0;
  bit  drain_calm = 1'b0;
  bit  send_calm = 1'b0;
  bit  took = 1'b0;
  int  beats_seen = 0;

  ray_cylinder_intersect_core dut (.*);

  ray_cylinder_intersect_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    took <= out_valid && out_ready;
    if (cycles > LIMIT) begin
      $display("ray_cylinder_intersect_core: mismatch");
      $finish;
    end
  end

  // hit side: random stalls per beat, calm stretches, one long hold-off
  always @(negedge clk) begin
    if (took) begin
      beats_seen++;
      if (beats_seen % 150 == 0) drain_calm = !drain_calm;
      drain_gap = drain_calm ? 0 : $urandom_range(0, 11);
    end
    if (rays_sent == 600 && hold_left == 0 && beats_seen < 600) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // called at a falling edge, returns at a falling edge after the beat
  task automatic send_ray(input ray_t r);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_dir_x  <= r.dx; in_dir_y  <= r.dy; in_dir_z  <= r.dz;
    in_orig_x <= r.ox; in_orig_y <= r.oy; in_orig_z <= r.oz;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    rays_sent++;
    if (rays_sent % 120 == 0) send_calm = !send_calm;
  endtask

  // random value of random magnitude, full range included
  function automatic logic signed [31:0] any_scale();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  function automatic ray_t rand_ray(input int unsigned rad);
    ray_t r;
    int   pick;
    pick = $urandom_range(0, 9);
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (pick < 6) begin
      // origin near the cylinder so that most rays hit
      r.dx = any_scale(); r.dy = any_scale(); r.dz = any_scale();
      r.ox = $signed($urandom) >>> (32 - $clog2(rad + 4) + $urandom_range(0, 2));
      r.oz = $signed($urandom) >>> (32 - $clog2(rad + 4) + $urandom_range(0, 2));
      r.oy = any_scale();
    end else if (pick < 8) begin
      r.dx = any_scale(); r.dy = any_scale(); r.dz = any_scale();
      r.ox = any_scale(); r.oy = any_scale(); r.oz = any_scale();
    end else if (pick == 8) begin
      r.dx = '0; r.dz = '0;
    end
    return r;
  endfunction

  task automatic settle();
    while (hits_pending != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  task automatic random_phase(input logic [31:0] rad_word);
    cfg_write(3'd0, rad_word);
    repeat (PHASE_LEN) send_ray(rand_ray(rad_word[30:0]));
    in_valid <= 1'b0;
    settle();
  endtask

  initial begin
    ray_t directed[$];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unit radius from reset
    directed = '{
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{-ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd0, ONE, 32'sd0, 5 * ONE, 32'sd0},
      '{ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 2 * ONE},
      '{ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE},
      '{32'sd1, 32'sd7, 32'sd1, -ONE, 32'sd3, 32'sd0},
      '{ONE, 32'sh7fffffff, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{32'sd1, 32'sh80000000, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000,
        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
        32'sh80000000, 32'sh80000000, 32'sh80000000},
      '{32'sh7fffffff, 32'sd0, 32'sh80000000, 32'sd0, 32'sd0, 32'sd0},
      '{ONE, ONE, ONE, -3 * ONE, 32'sh7fff0000, 32'sd0},
      '{32'shffffffff, 32'sd1, 32'shffffffff, 32'sd100, 32'sd0, -32'sd100}
    };
    foreach (directed[i]) send_ray(directed[i]);
    in_valid <= 1'b0;
    settle();

    random_phase(32'h0001_0000);
    random_phase(32'h0000_0000);
    random_phase(32'h7fff_ffff);
    cfg_write(3'd4, 32'h0000_0100);   // no register there
    random_phase(32'h8000_0003);      // top bit dropped
    random_phase({1'b0, 31'($urandom_range(1, 32'h00ff_ffff))});
    random_phase({1'b0, 31'($urandom)});
    random_phase(32'h0001_0000);

    while (hits_pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (errors == 0)
      $display("ray_cylinder_intersect_core: match");
    else
      $display("ray_cylinder_intersect_core: mismatch");
    $finish;
  end

endmodule
